[rtl/ulbd_pkg.sv]
package ulbd_pkg;

   // Default widths
   localparam int DEF_ADDR_WIDTH = 16;
   localparam int DEF_DATA_WIDTH = 8;

   // Request kinds, carried on tuser
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_RX    = 2'd1;
   localparam logic [1:0] REQ_RDATA = 2'd2;

   // Transfer modes
   localparam logic [2:0] MODE_OUT_CHAR   = 3'd0;
   localparam logic [2:0] MODE_OUT_STR    = 3'd1;
   localparam logic [2:0] MODE_IN_CHAR    = 3'd2;
   localparam logic [2:0] MODE_IN_CHAR_EC = 3'd3;
   localparam logic [2:0] MODE_IN_LINE    = 3'd4;
   localparam logic [2:0] MODE_IN_LINE_EC = 3'd5;

   // Control register indexes
   localparam logic CSR_TERMINATOR = 1'b0;
   localparam logic CSR_NEWLINE    = 1'b1;

   // Character codes and register reset values
   localparam logic [7:0] BACKSPACE_CODE = 8'h08;
   localparam logic [7:0] TERM_RESET     = 8'h00;
   localparam logic [7:0] NEWLINE_RESET  = 8'h0a;

endpackage

[rtl/ulbd_engine.sv]
module ulbd_engine #(
   parameter int ADDR_WIDTH = ulbd_pkg::DEF_ADDR_WIDTH,
   parameter int DATA_WIDTH = ulbd_pkg::DEF_DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [1:0]            req_type,
   input  logic [2:0]            mode,
   input  logic [ADDR_WIDTH-1:0] out_base,
   input  logic [ADDR_WIDTH-1:0] in_base,
   input  logic [DATA_WIDTH-1:0] data_byte,
   input  logic [DATA_WIDTH-1:0] terminator_code,
   input  logic [DATA_WIDTH-1:0] newline_code,
   output logic                  tx_valid,
   output logic [DATA_WIDTH-1:0] tx_byte,
   output logic                  write_valid,
   output logic [ADDR_WIDTH-1:0] write_addr,
   output logic [DATA_WIDTH-1:0] write_data,
   output logic                  read_valid,
   output logic [ADDR_WIDTH-1:0] read_addr,
   output logic                  done_res,
   output logic                  rejected
);
   import ulbd_pkg::*;

   logic                  busy_ff, busy_in;
   logic [2:0]            mode_ff, mode_in;
   logic [ADDR_WIDTH-1:0] src_ff, src_in;
   logic [ADDR_WIDTH-1:0] dst_ff, dst_in;
   logic [ADDR_WIDTH-1:0] offset_ff, offset_in;

   logic [ADDR_WIDTH-1:0] offset_inc;
   logic [ADDR_WIDTH-1:0] store_addr;
   logic [DATA_WIDTH-1:0] bs_code;

   assign offset_inc = offset_ff + ADDR_WIDTH'(1);
   assign store_addr = dst_ff + offset_ff;
   assign bs_code    = DATA_WIDTH'(BACKSPACE_CODE);

   // Result and next state for the beat in hand
   always_comb begin
      busy_in     = busy_ff;
      mode_in     = mode_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      offset_in   = offset_ff;
      tx_valid    = 1'b0;
      tx_byte     = '0;
      write_valid = 1'b0;
      write_addr  = '0;
      write_data  = '0;
      read_valid  = 1'b0;
      read_addr   = '0;
      done_res    = 1'b0;
      rejected    = 1'b0;
      case (req_type)
         REQ_START: begin
            if (busy_ff || mode > MODE_IN_LINE_EC) begin
               rejected = 1'b1;
            end else begin
               busy_in   = 1'b1;
               mode_in   = mode;
               src_in    = out_base;
               dst_in    = in_base;
               offset_in = '0;
               if (mode <= MODE_OUT_STR) begin
                  read_valid = 1'b1;
                  read_addr  = out_base;
               end
            end
         end
         REQ_RDATA: begin
            if (!busy_ff || mode_ff > MODE_OUT_STR) begin
               rejected = 1'b1;
            end else if (mode_ff == MODE_OUT_CHAR) begin
               tx_valid = 1'b1;
               tx_byte  = data_byte;
               done_res = 1'b1;
               busy_in  = 1'b0;
            end else if (data_byte == terminator_code) begin
               done_res = 1'b1;
               busy_in  = 1'b0;
            end else begin
               tx_valid   = 1'b1;
               tx_byte    = data_byte;
               offset_in  = offset_inc;
               read_valid = 1'b1;
               read_addr  = src_ff + offset_inc;
            end
         end
         REQ_RX: begin
            if (!busy_ff || mode_ff < MODE_IN_CHAR) begin
               rejected = 1'b1;
            end else begin
               // echo modes send every byte back
               if (mode_ff == MODE_IN_CHAR_EC || mode_ff == MODE_IN_LINE_EC) begin
                  tx_valid = 1'b1;
                  tx_byte  = data_byte;
               end
               if (mode_ff <= MODE_IN_CHAR_EC) begin
                  write_valid = 1'b1;
                  write_addr  = store_addr;
                  write_data  = data_byte;
                  done_res    = 1'b1;
                  busy_in     = 1'b0;
               end else if (data_byte == newline_code) begin
                  write_valid = 1'b1;
                  write_addr  = store_addr;
                  write_data  = terminator_code;
                  done_res    = 1'b1;
                  busy_in     = 1'b0;
               end else if (data_byte == bs_code && offset_ff != '0) begin
                  offset_in = offset_ff - ADDR_WIDTH'(1);
               end else begin
                  // backspace at the line start is stored like any byte
                  write_valid = 1'b1;
                  write_addr  = store_addr;
                  write_data  = data_byte;
                  offset_in   = offset_inc;
               end
            end
         end
         default: begin
            rejected = 1'b1;
         end
      endcase
   end

   // Transfer state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (step) begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         src_ff    <= '0;
         dst_ff    <= '0;
         offset_ff <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
         offset_ff <= offset_in;
      end
   end

endmodule

[rtl/uart_line_buffer_dma.sv]
// A req beat is registered in the input stage, and its result in the result stage, before its rsp beat.
// Throughput: one beat per cycle unless rsp_tready holds the result stage; each beat's
// compares and address adds are done between the input register and the result register.
// Reset: synchronous, active high; engine idle, offset and bases cleared,
// terminator 0x00 and newline 0x0a, both stages empty.
module uart_line_buffer_dma #(
   parameter int ADDR_WIDTH = ulbd_pkg::DEF_ADDR_WIDTH,
   parameter int DATA_WIDTH = ulbd_pkg::DEF_DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // slave side
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mode, out_base, in_base, data_byte; zero padded to bytes
   input  logic [((3+2*ADDR_WIDTH+DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   // req_type
   input  logic [1:0]            req_tuser,
   // master side
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tx_valid, tx_byte, write_valid, write_addr, write_data, read_valid,
   // read_addr, done_res, rejected; zero padded to bytes
   output logic [((5+2*ADDR_WIDTH+2*DATA_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // control registers
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [DATA_WIDTH-1:0] csr_wdata
);
   import ulbd_pkg::*;

   localparam int RSP_FIELDS_W = 5 + 2*ADDR_WIDTH + 2*DATA_WIDTH;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int OB_LO        = 3;
   localparam int IB_LO        = 3 + ADDR_WIDTH;
   localparam int DB_LO        = 3 + 2*ADDR_WIDTH;

   // Control registers
   logic [DATA_WIDTH-1:0] term_ff;
   logic [DATA_WIDTH-1:0] newline_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff    <= DATA_WIDTH'(TERM_RESET);
         newline_ff <= DATA_WIDTH'(NEWLINE_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_TERMINATOR: term_ff    <= csr_wdata;
            CSR_NEWLINE:    newline_ff <= csr_wdata;
            default:        term_ff    <= term_ff;
         endcase
      end
   end

   // Input stage
   logic                  in_valid_ff;
   logic [1:0]            in_type_ff;
   logic [2:0]            in_mode_ff;
   logic [ADDR_WIDTH-1:0] in_ob_ff;
   logic [ADDR_WIDTH-1:0] in_ib_ff;
   logic [DATA_WIDTH-1:0] in_data_ff;

   logic out_valid_ff;
   logic out_free;
   logic step;
   logic req_fire;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_type_ff <= req_tuser;
         in_mode_ff <= req_tdata[2:0];
         in_ob_ff   <= req_tdata[OB_LO +: ADDR_WIDTH];
         in_ib_ff   <= req_tdata[IB_LO +: ADDR_WIDTH];
         in_data_ff <= req_tdata[DB_LO +: DATA_WIDTH];
      end
   end

   // Engine
   logic                  tx_valid;
   logic [DATA_WIDTH-1:0] tx_byte;
   logic                  write_valid;
   logic [ADDR_WIDTH-1:0] write_addr;
   logic [DATA_WIDTH-1:0] write_data;
   logic                  read_valid;
   logic [ADDR_WIDTH-1:0] read_addr;
   logic                  done_res;
   logic                  rejected;

   ulbd_engine #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .req_type        (in_type_ff),
      .mode            (in_mode_ff),
      .out_base        (in_ob_ff),
      .in_base         (in_ib_ff),
      .data_byte       (in_data_ff),
      .terminator_code (term_ff),
      .newline_code    (newline_ff),
      .tx_valid        (tx_valid),
      .tx_byte         (tx_byte),
      .write_valid     (write_valid),
      .write_addr      (write_addr),
      .write_data      (write_data),
      .read_valid      (read_valid),
      .read_addr       (read_addr),
      .done_res        (done_res),
      .rejected        (rejected)
   );

   // Result stage
   logic [RSP_FIELDS_W-1:0] rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= {rejected, done_res, read_addr, read_valid, write_data,
                    write_addr, write_valid, tx_byte, tx_valid};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_ff);

   // Checks
   localparam int RD_V  = 2 + 2*DATA_WIDTH + ADDR_WIDTH;
   localparam int WR_V  = 1 + DATA_WIDTH;
   localparam int DONE  = RSP_FIELDS_W - 2;
   localparam int REJ   = RSP_FIELDS_W - 1;

   a_rej_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff[REJ] |-> !rsp_ff[DONE] && !rsp_ff[RD_V] && !rsp_ff[WR_V]
         && !rsp_ff[0])
      else $error("rejected beat carries an action");

   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_ff[RD_V] && rsp_ff[WR_V]))
      else $error("read and write issued in one beat");

   a_done_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff[DONE] |-> !rsp_ff[RD_V])
      else $error("read issued on a finishing beat");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_type_ff))
      else $error("input stage lost a beat under back-pressure");

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
   import ulbd_pkg::*;

   localparam int AW    = DEF_ADDR_WIDTH;
   localparam int DW    = DEF_DATA_WIDTH;
   localparam int REQ_W = ((3 + 2*AW + DW + 7) / 8) * 8;
   localparam int RSP_W = ((5 + 2*AW + 2*DW + 7) / 8) * 8;

   // request kind and modes with no name in the package
   localparam logic [1:0] REQ_BAD     = 2'd3;
   localparam logic [2:0] MODE_SPARE6 = 3'd6;
   localparam logic [2:0] MODE_SPARE7 = 3'd7;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 260;
   localparam int DRAIN_WAIT  = 4;

   // one request beat
   typedef struct packed {
      logic [1:0]    kind;
      logic [2:0]    mode;
      logic [AW-1:0] out_base;
      logic [AW-1:0] in_base;
      logic [DW-1:0] data;
   } req_t;

   // one response beat, lowest field last so it maps straight onto rsp_tdata
   typedef struct packed {
      logic          rejected;
      logic          done;
      logic [AW-1:0] rd_addr;
      logic          rd_valid;
      logic [DW-1:0] wr_data;
      logic [AW-1:0] wr_addr;
      logic          wr_valid;
      logic [DW-1:0] tx_byte;
      logic          tx_valid;
   } rsp_t;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;   // mode, out_base, in_base, data_byte
   logic [1:0]       req_tuser  = '0;   // req_type
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // tx_valid, tx_byte, write_valid, write_addr, write_data, read_valid,
   // read_addr, done_res, rejected
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we     = 1'b0;
   logic             csr_index  = 1'b0;
   logic [DW-1:0]    csr_wdata  = '0;

   uart_line_buffer_dma dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // engine copy kept by the bench
   logic          eng_busy    = 1'b0;
   logic [2:0]    eng_mode    = '0;
   logic [AW-1:0] src_base    = '0;
   logic [AW-1:0] dst_base    = '0;
   logic [AW-1:0] xfer_offset = '0;
   logic [DW-1:0] term_code   = TERM_RESET;
   logic [DW-1:0] nl_code     = NEWLINE_RESET;

   rsp_t   pending_rsp[$];
   int     fail_count  = 0;
   int     cycle_count = 0;
   int     burst_left  = 0;
   int     good_items  = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // works out the response to one request and moves the engine on
   function automatic rsp_t engine_step(input req_t r);
      rsp_t e;
      e = '0;
      case (r.kind)
         REQ_START: begin
            if (eng_busy || r.mode > MODE_IN_LINE_EC) begin
               e.rejected = 1'b1;
            end else begin
               eng_busy    = 1'b1;
               eng_mode    = r.mode;
               src_base    = r.out_base;
               dst_base    = r.in_base;
               xfer_offset = '0;
               if (r.mode == MODE_OUT_CHAR || r.mode == MODE_OUT_STR) begin
                  e.rd_valid = 1'b1;
                  e.rd_addr  = r.out_base;
               end
            end
         end
         REQ_RDATA: begin
            if (!eng_busy || eng_mode > MODE_OUT_STR) begin
               e.rejected = 1'b1;
            end else if (eng_mode == MODE_OUT_CHAR) begin
               e.tx_valid = 1'b1;
               e.tx_byte  = r.data;
               e.done     = 1'b1;
               eng_busy   = 1'b0;
            end else if (r.data == term_code) begin
               e.done   = 1'b1;
               eng_busy = 1'b0;
            end else begin
               e.tx_valid  = 1'b1;
               e.tx_byte   = r.data;
               xfer_offset = xfer_offset + 1'b1;
               e.rd_valid  = 1'b1;
               e.rd_addr   = src_base + xfer_offset;
            end
         end
         REQ_RX: begin
            if (!eng_busy || eng_mode < MODE_IN_CHAR) begin
               e.rejected = 1'b1;
            end else begin
               if (eng_mode == MODE_IN_CHAR_EC || eng_mode == MODE_IN_LINE_EC) begin
                  e.tx_valid = 1'b1;
                  e.tx_byte  = r.data;
               end
               if (eng_mode == MODE_IN_CHAR || eng_mode == MODE_IN_CHAR_EC) begin
                  e.wr_valid = 1'b1;
                  e.wr_addr  = dst_base + xfer_offset;
                  e.wr_data  = r.data;
                  e.done     = 1'b1;
                  eng_busy   = 1'b0;
               end else if (r.data == nl_code) begin
                  // newline is checked before backspace
                  e.wr_valid = 1'b1;
                  e.wr_addr  = dst_base + xfer_offset;
                  e.wr_data  = term_code;
                  e.done     = 1'b1;
                  eng_busy   = 1'b0;
               end else if (r.data == BACKSPACE_CODE && xfer_offset != '0) begin
                  xfer_offset = xfer_offset - 1'b1;
               end else begin
                  e.wr_valid  = 1'b1;
                  e.wr_addr   = dst_base + xfer_offset;
                  e.wr_data   = r.data;
                  xfer_offset = xfer_offset + 1'b1;
               end
            end
         end
         default: begin
            e.rejected = 1'b1;
         end
      endcase
      return e;
   endfunction

   // request with random filler in the fields the kind does not use
   function automatic req_t make_req(input logic [1:0] kind, input logic [DW-1:0] data);
      req_t r;
      r.kind     = kind;
      r.mode     = 3'($urandom);
      r.out_base = AW'($urandom);
      r.in_base  = AW'($urandom);
      r.data     = data;
      return r;
   endfunction

   function automatic req_t make_start(input logic [2:0] mode, input logic [AW-1:0] ob,
                                       input logic [AW-1:0] ib);
      req_t r;
      r          = make_req(REQ_START, DW'($urandom));
      r.mode     = mode;
      r.out_base = ob;
      r.in_base  = ib;
      return r;
   endfunction

   // base addresses lean towards the top of memory so that wrap is hit often
   function automatic logic [AW-1:0] pick_base();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0)
         return '0;
      else if (roll <= 2)
         return {{(AW-3){1'b1}}, 3'($urandom)};
      else
         return AW'($urandom);
   endfunction

   // sends one beat; the sender runs in bursts with gaps between them
   task automatic send_beat(input req_t r);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         if ($urandom_range(0, 7) == 0)
            burst_left = $urandom_range(60, 160);
         else
            burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({r.data, r.in_base, r.out_base, r.mode});
      req_tuser  <= r.kind;
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(engine_step(r));
      burst_left--;
   endtask

   // holds the sender until every response is back and the pipe is empty
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [DW-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TERMINATOR)
         term_code = value;
      else
         nl_code = value;
   endtask

   // response check against the oldest prediction
   always @(posedge clock) begin : check_rsp
      rsp_t got;
      rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_t'(rsp_tdata[$bits(rsp_t)-1:0]);
         if (pending_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("tb: response with none expected: %h", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                got.wr_valid !== want.wr_valid || got.wr_addr !== want.wr_addr ||
                got.wr_data !== want.wr_data || got.rd_valid !== want.rd_valid ||
                got.rd_addr !== want.rd_addr || got.done !== want.done ||
                got.rejected !== want.rejected) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("tb: mismatch tx %b/%h wr %b/%h/%h rd %b/%h done %b rej %b",
                           got.tx_valid, got.tx_byte, got.wr_valid, got.wr_addr,
                           got.wr_data, got.rd_valid, got.rd_addr, got.done, got.rejected);
                  $display("tb:   wanted tx %b/%h wr %b/%h/%h rd %b/%h done %b rej %b",
                           want.tx_valid, want.tx_byte, want.wr_valid, want.wr_addr,
                           want.wr_data, want.rd_valid, want.rd_addr, want.done,
                           want.rejected);
               end
            end
         end
      end
   end

   // receiver stalls: always ready, random, or a fixed 3-in-8 pattern
   always @(posedge clock) begin : stall_rsp
      int stall_tick;
      int stall_style;
      if (stall_tick % 300 == 0)
         stall_style = $urandom_range(0, 2);
      stall_tick++;
      case (stall_style)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 99) >= 35);
         default: rsp_tready <= ((stall_tick & 7) > 2);
      endcase
   end

   // reading from memory: single char, then a string that wraps the address
   task automatic test_output_modes();
      send_beat(make_start(MODE_OUT_CHAR, {AW{1'b1}}, '0));
      send_beat(make_req(REQ_RDATA, 8'hff));
      send_beat(make_start(MODE_OUT_STR, {{(AW-1){1'b1}}, 1'b0}, {AW{1'b1}}));
      send_beat(make_req(REQ_RDATA, 8'h41));
      send_beat(make_req(REQ_RX, 8'h42));       // serial byte in an output mode
      send_beat(make_req(REQ_RDATA, 8'h80));
      send_beat(make_req(REQ_RDATA, term_code));
      send_beat(make_req(REQ_RDATA, 8'h55));    // memory data while idle
   endtask

   // single chars with and without echo, then line editing at the top of memory
   task automatic test_input_modes();
      send_beat(make_start(MODE_IN_CHAR, '0, {AW{1'b1}}));
      send_beat(make_req(REQ_RX, 8'h00));
      send_beat(make_start(MODE_IN_CHAR_EC, {AW{1'b1}}, '0));
      send_beat(make_req(REQ_RX, 8'hff));
      send_beat(make_start(MODE_IN_LINE, '0, {AW{1'b1}}));
      send_beat(make_req(REQ_RX, BACKSPACE_CODE));   // stored at offset zero
      send_beat(make_req(REQ_RX, 8'h61));
      send_beat(make_req(REQ_RX, BACKSPACE_CODE));   // steps back
      send_beat(make_start(MODE_OUT_CHAR, '0, '0));   // start while busy
      send_beat(make_req(REQ_RDATA, 8'h62));         // memory data in an input mode
      send_beat(make_req(REQ_RX, nl_code));
      send_beat(make_start(MODE_IN_LINE_EC, '0, 16'h1234));
      send_beat(make_req(REQ_RX, 8'h7e));
      send_beat(make_req(REQ_RX, nl_code));
   endtask

   // malformed requests while idle
   task automatic test_bad_requests();
      send_beat(make_start(MODE_SPARE6, 16'haaaa, 16'h5555));
      send_beat(make_start(MODE_SPARE7, 16'h5555, 16'haaaa));
      send_beat(make_req(REQ_BAD, 8'hff));
      send_beat(make_req(REQ_RX, 8'h00));
   endtask

   // newline equal to backspace, and a terminator of all ones
   task automatic test_register_extremes();
      write_reg(CSR_TERMINATOR, 8'hff);
      write_reg(CSR_NEWLINE, BACKSPACE_CODE);
      send_beat(make_start(MODE_IN_LINE, '0, 16'h0100));
      send_beat(make_req(REQ_RX, 8'h31));
      send_beat(make_req(REQ_RX, BACKSPACE_CODE));
      send_beat(make_start(MODE_OUT_STR, 16'hfffe, '0));
      send_beat(make_req(REQ_RDATA, 8'h00));
      send_beat(make_req(REQ_RDATA, 8'hff));
   endtask

   // one random item of any kind, mode or content
   task automatic send_noise();
      req_t r;
      r      = make_req(2'($urandom), DW'($urandom));
      r.mode = 3'($urandom);
      send_beat(r);
   endtask

   // mostly complete transfers with random content, some noise mixed in
   task automatic test_random_transfers(input int count);
      int      len;
      logic [2:0]    mode;
      logic [DW-1:0] b;
      int      target;
      target = good_items + count;
      while (good_items < target) begin
         if ($urandom_range(0, 99) < 10) begin
            send_noise();
         end else begin
            mode = 3'($urandom_range(0, 5));
            send_beat(make_start(mode, pick_base(), pick_base()));
            good_items++;
            case (mode)
               MODE_OUT_CHAR: begin
                  send_beat(make_req(REQ_RDATA, DW'($urandom)));
                  good_items++;
               end
               MODE_OUT_STR: begin
                  len = $urandom_range(0, 8);
                  repeat (len) begin
                     b = DW'($urandom);
                     if (b == term_code && $urandom_range(0, 19) != 0)
                        b = ~b;
                     if ($urandom_range(0, 19) == 0)
                        send_noise();
                     send_beat(make_req(REQ_RDATA, b));
                     good_items++;
                  end
                  send_beat(make_req(REQ_RDATA, term_code));
                  good_items++;
               end
               MODE_IN_CHAR, MODE_IN_CHAR_EC: begin
                  send_beat(make_req(REQ_RX, DW'($urandom)));
                  good_items++;
               end
               default: begin
                  len = $urandom_range(0, 12);
                  repeat (len) begin
                     if ($urandom_range(0, 4) == 0)
                        b = BACKSPACE_CODE;
                     else
                        b = DW'($urandom);
                     if (b == nl_code)
                        b = ~b;
                     if ($urandom_range(0, 19) == 0)
                        send_noise();
                     send_beat(make_req(REQ_RX, b));
                     good_items++;
                  end
                  send_beat(make_req(REQ_RX, nl_code));
                  good_items++;
               end
            endcase
         end
      end
   endtask

   // several register settings, extremes included
   task automatic test_register_sweep();
      write_reg(CSR_TERMINATOR, TERM_RESET);
      write_reg(CSR_NEWLINE, NEWLINE_RESET);
      test_random_transfers(PHASE_ITEMS);
      write_reg(CSR_TERMINATOR, 8'hff);
      write_reg(CSR_NEWLINE, 8'hff);
      test_random_transfers(PHASE_ITEMS);
      write_reg(CSR_TERMINATOR, 8'h00);
      write_reg(CSR_NEWLINE, 8'h00);
      test_random_transfers(PHASE_ITEMS);
      write_reg(CSR_TERMINATOR, 8'hff);
      write_reg(CSR_NEWLINE, 8'h0d);
      test_random_transfers(PHASE_ITEMS);
      write_reg(CSR_TERMINATOR, DW'($urandom));
      write_reg(CSR_NEWLINE, DW'($urandom));
      test_random_transfers(PHASE_ITEMS);
   endtask

   initial begin
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_output_modes();
      test_input_modes();
      test_bad_requests();
      test_register_extremes();
      test_register_sweep();

      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
